### sv/tsc_pkg.sv
package tsc_pkg;

  // field widths
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int TOL_W   = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOL = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam int unsigned ORDER_LIMIT_DEF = 100;

  // datapath widths
  localparam int X_W    = ANGLE_W + 1;  // reduced angle, Q9.24 signed
  localparam int AX_W   = 32;           // |x| in Q.30
  localparam int XX_W   = 34;           // x*x in Q.30
  localparam int TERM_W = 33;           // series term magnitude, Q.30
  localparam int MA_W   = 33;           // multiplier operand a
  localparam int MB_W   = 17;           // multiplier operand b (half of |x| or of x*x)
  localparam int ACC_W  = MA_W + 2 * MB_W;
  localparam int RND_SH = 30;
  localparam int DIVD_W = 40;           // dividend / quotient
  localparam int DIV_STEP = 8;          // quotient bits per cycle
  localparam int DIV_CYC  = DIVD_W / DIV_STEP;
  localparam int SUM_W  = 36;

  localparam logic signed [X_W-1:0] PI_X     = X_W'(52707179);
  localparam logic signed [X_W-1:0] NEG_PI_X = -X_W'(52707179);
  localparam logic signed [X_W-1:0] TWO_PI_X = X_W'(105414358);

  localparam logic [TERM_W-1:0]       ONE_TERM = TERM_W'(64'd1 << RND_SH);
  localparam logic signed [SUM_W-1:0] ONE_SUM  = SUM_W'(64'd1 << RND_SH);
  localparam logic signed [SUM_W-1:0] NEG_ONE_SUM = -SUM_W'(64'd1 << RND_SH);
  localparam logic [ACC_W:0]          HALF_LSB = (ACC_W + 1)'(64'd1 << (RND_SH - 1));

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REDUCE,
    OP_SQ_LO,
    OP_SQ_HI,
    OP_SQ_RND,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACCUM,
    OP_FINISH
  } tsc_op_e;

  typedef struct packed {
    logic    load;
    tsc_op_e op;
    logic    fail;
  } tsc_cmd_t;

  typedef struct packed {
    logic in_range;
    logic sine;
    logic tol_hit;
    logic out_full;
  } tsc_sts_t;

endpackage

### sv/tsc_ctrl.sv
module tsc_ctrl import tsc_pkg::*; #(
  parameter int unsigned ORDER_LIMIT = ORDER_LIMIT_DEF,
  parameter int D_W = 2 * $clog2(ORDER_LIMIT + 3)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  tsc_sts_t       sts_i,
  output tsc_cmd_t       cmd_o,
  output logic [D_W-1:0] div_o
);

  localparam int N_W   = D_W / 2;
  localparam int CNT_W = $clog2(DIV_CYC);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQ_LO,
    ST_SQ_HI,
    ST_SQ_RND,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_ACCUM,
    ST_DONE,
    ST_FINISH
  } state_e;

  state_e           state_q;
  tsc_op_e          op_q;
  logic             ready_q;
  logic             fail_q;
  logic [N_W-1:0]   n_q;
  logic [D_W-1:0]   d_q;
  logic [CNT_W-1:0] cnt_q;
  logic             accept;
  logic [N_W-1:0]   n_next;
  logic [N_W-1:0]   n_odd;

  assign accept = s_tvalid_i && ready_q;
  assign n_next = n_q + N_W'(2);
  assign n_odd  = n_q + N_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
      ready_q <= 1'b1;
      fail_q  <= 1'b0;
      n_q     <= '0;
      d_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_REDUCE;
            op_q    <= OP_REDUCE;
            ready_q <= 1'b0;
            fail_q  <= 1'b0;
          end
        end
        ST_REDUCE: begin
          if (sts_i.in_range) begin
            state_q <= ST_SQ_LO;
            op_q    <= OP_SQ_LO;
          end
        end
        ST_SQ_LO: begin
          state_q <= ST_SQ_HI;
          op_q    <= OP_SQ_HI;
        end
        ST_SQ_HI: begin
          state_q <= ST_SQ_RND;
          op_q    <= OP_SQ_RND;
          n_q     <= N_W'(sts_i.sine);
        end
        ST_SQ_RND: begin
          state_q <= ST_CHECK;
          op_q    <= OP_NONE;
        end
        ST_CHECK: begin
          if (n_q > N_W'(ORDER_LIMIT)) begin
            state_q <= ST_DONE;
            op_q    <= OP_NONE;
            fail_q  <= 1'b1;
          end else begin
            state_q <= ST_MUL_LO;
            op_q    <= OP_MUL_LO;
            n_q     <= n_next;
            d_q     <= D_W'(n_next) * D_W'(n_odd);
          end
        end
        ST_MUL_LO: begin
          state_q <= ST_MUL_HI;
          op_q    <= OP_MUL_HI;
        end
        ST_MUL_HI: begin
          state_q <= ST_DIV_INIT;
          op_q    <= OP_DIV_INIT;
        end
        ST_DIV_INIT: begin
          state_q <= ST_DIV;
          op_q    <= OP_DIV_STEP;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
            state_q <= ST_ACCUM;
            op_q    <= OP_ACCUM;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_ACCUM: begin
          // the term just added decides whether the series ends
          if (sts_i.tol_hit) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_CHECK;
          end
          op_q <= OP_NONE;
        end
        ST_DONE: begin
          if (!sts_i.out_full) begin
            state_q <= ST_FINISH;
            op_q    <= OP_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
          op_q    <= OP_NONE;
          ready_q <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          op_q    <= OP_NONE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready_o = ready_q;
  assign cmd_o      = '{load: accept, op: op_q, fail: fail_q};
  assign div_o      = d_q;

endmodule

### sv/tsc_dp.sv
module tsc_dp import tsc_pkg::*; #(
  parameter int unsigned ORDER_LIMIT = ORDER_LIMIT_DEF,
  parameter int D_W = 2 * $clog2(ORDER_LIMIT + 3)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsc_cmd_t           cmd_i,
  input  logic [D_W-1:0]     div_i,
  input  logic [ANGLE_W-1:0] angle_i,
  input  logic               mode_i,
  input  logic [TOL_W-1:0]   tol_i,
  input  logic               m_tready_i,
  output tsc_sts_t           sts_o,
  output logic               m_tvalid_o,
  output logic [VALUE_W-1:0] value_o,
  output logic               failed_o
);

  localparam int REM_W = D_W + 1;
  localparam int P_W   = ACC_W + 1 - RND_SH;

  logic signed [X_W-1:0]   x_q;
  logic                    sine_q;
  logic                    neg_q;
  logic [XX_W-1:0]         xx_q;
  logic [TERM_W-1:0]       term_q;
  logic [ACC_W-1:0]        acc_q;
  logic [DIVD_W-1:0]       divd_q;
  logic [REM_W-1:0]        rem_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    minus_q;
  logic                    m_valid_q;
  logic [VALUE_W-1:0]      value_q;
  logic                    failed_q;

  logic [X_W-1:0]          absx;
  logic [AX_W-1:0]         ax;
  logic [MA_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [MA_W+MB_W-1:0]    prod;
  logic [ACC_W:0]          rnd;
  logic [P_W-1:0]          rnd_p;
  logic [DIVD_W-1:0]       divd_d;
  logic [REM_W-1:0]        rem_d;
  logic [TERM_W-1:0]       quot;
  logic signed [SUM_W-1:0] sat;
  logic signed [SUM_W-1:0] fin;
  logic                    in_range;

  assign in_range = !(x_q > PI_X) && !(x_q <= NEG_PI_X);
  assign absx     = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
  // |x| < 2^26 after reduction, Q8.24 -> Q.30
  assign ax       = {absx[AX_W-7:0], 6'b0};

  always_comb begin
    case (cmd_i.op)
      OP_SQ_LO: begin
        mul_a = MA_W'(ax);
        mul_b = ax[MB_W-1:0];
      end
      OP_SQ_HI: begin
        mul_a = MA_W'(ax);
        mul_b = MB_W'(ax[AX_W-1:MB_W]);
      end
      OP_MUL_HI: begin
        mul_a = term_q;
        mul_b = xx_q[XX_W-1:MB_W];
      end
      default: begin
        mul_a = term_q;
        mul_b = xx_q[MB_W-1:0];
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign rnd   = (ACC_W + 1)'(acc_q) + HALF_LSB;
  assign rnd_p = rnd[ACC_W:RND_SH];
  assign quot  = divd_q[TERM_W-1:0];

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [REM_W-1:0]  r;
    logic [DIVD_W-1:0] q;
    r = rem_q;
    q = divd_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {r[REM_W-2:0], q[DIVD_W-1]};
      q = {q[DIVD_W-2:0], 1'b0};
      if (r >= REM_W'(div_i)) begin
        r    = r - REM_W'(div_i);
        q[0] = 1'b1;
      end
    end
    rem_d  = r;
    divd_d = q;
  end

  always_comb begin
    if (sum_q > ONE_SUM) begin
      sat = ONE_SUM;
    end else if (sum_q < NEG_ONE_SUM) begin
      sat = NEG_ONE_SUM;
    end else begin
      sat = sum_q;
    end
    if (cmd_i.fail) begin
      fin = '0;
    end else if (sine_q && neg_q) begin
      fin = -sat;
    end else begin
      fin = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= {angle_i[ANGLE_W-1], angle_i};
      sine_q <= mode_i;
    end
    case (cmd_i.op)
      OP_REDUCE: begin
        if (x_q > PI_X) begin
          x_q <= x_q - TWO_PI_X;
        end else if (x_q <= NEG_PI_X) begin
          x_q <= x_q + TWO_PI_X;
        end
      end
      OP_SQ_LO, OP_MUL_LO: begin
        acc_q <= ACC_W'(prod);
      end
      OP_SQ_HI, OP_MUL_HI: begin
        acc_q <= acc_q + (ACC_W'(prod) << MB_W);
      end
      OP_SQ_RND: begin
        xx_q    <= rnd[RND_SH +: XX_W];
        neg_q   <= x_q[X_W-1];
        minus_q <= 1'b1;
        if (sine_q) begin
          term_q <= TERM_W'(ax);
          sum_q  <= $signed(SUM_W'(ax));
        end else begin
          term_q <= ONE_TERM;
          sum_q  <= $signed(SUM_W'(ONE_TERM));
        end
      end
      OP_DIV_INIT: begin
        // add half the divisor for round half up
        divd_q <= DIVD_W'(rnd_p) + DIVD_W'(div_i >> 1);
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        divd_q <= divd_d;
        rem_q  <= rem_d;
      end
      OP_ACCUM: begin
        term_q  <= quot;
        minus_q <= !minus_q;
        if (minus_q) begin
          sum_q <= sum_q - $signed(SUM_W'(quot));
        end else begin
          sum_q <= sum_q + $signed(SUM_W'(quot));
        end
      end
      OP_FINISH: begin
        value_q  <= VALUE_W'(fin);
        failed_q <= cmd_i.fail;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINISH) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign sts_o = '{
    in_range: in_range,
    sine:     sine_q,
    tol_hit:  divd_q < DIVD_W'(tol_i),
    out_full: m_valid_q && !m_tready_i
  };

  assign m_tvalid_o = m_valid_q;
  assign value_o    = value_q;
  assign failed_o   = failed_q;

endmodule

### sv/taylor_sine_cosine.sv
// Sine or cosine of an angle in radians (Q8.24 in, Q2.30 out) by Taylor series.
// One word is worked on at a time. The angle is first folded by 2*pi, one add a
// cycle, then x*x is formed on the shared 33x17 multiplier from a low and a high pass
// and a rounding. Each series term then takes the order check, two multiplier passes,
// rounding, the 8-bit-per-cycle divider by n*(n-1), and the signed accumulate. With a
// tolerance of one LSB an angle near pi needs about 11 terms; a tolerance of zero runs
// terms until the order n exceeds ORDER_LIMIT and flags the result as failed with
// value 0. A new word is taken as soon as the previous result sits in the output
// register, even if not yet read.
// term_tolerance lies at byte address 0 of the register port (reset 1).
module taylor_sine_cosine import tsc_pkg::*; #(
  parameter int unsigned ORDER_LIMIT = ORDER_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [ANGLE_W-1:0] s_tdata_i,   // angle
  input  logic               s_tuser_i,   // mode
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [VALUE_W-1:0] m_tdata_o,   // value
  output logic               m_tuser_o,   // failed
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic               pready_o
);

  localparam int D_W = 2 * $clog2(ORDER_LIMIT + 3);

  logic [TOL_W-1:0] tol_q;
  logic             cfg_wr;
  tsc_cmd_t         cmd;
  tsc_sts_t         sts;
  logic [D_W-1:0]   div;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_wr && (paddr_i[PADDR_W-1] == REG_TOL)) begin
      tol_q <= pwdata_i[TOL_W-1:0];
    end
  end

  assign prdata_o = (paddr_i[PADDR_W-1] == REG_TOL) ? PDATA_W'(tol_q) : '0;

  tsc_ctrl #(
    .ORDER_LIMIT (ORDER_LIMIT),
    .D_W         (D_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .div_o      (div)
  );

  tsc_dp #(
    .ORDER_LIMIT (ORDER_LIMIT),
    .D_W         (D_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .div_i      (div),
    .angle_i    (s_tdata_i),
    .mode_i     (s_tuser_i),
    .tol_i      (tol_q),
    .m_tready_i (m_tready_i),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .value_o    (m_tdata_o),
    .failed_o   (m_tuser_o)
  );

endmodule

### sv/tsc_chk.sv
module tsc_chk import tsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_tvalid_i,
  input logic               s_tready_o,
  input logic               m_tvalid_o,
  input logic               m_tready_i,
  input logic [VALUE_W-1:0] m_tdata_o,
  input logic               m_tuser_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("output word changed while stalled");

  // one word in flight: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input accepted twice in a row");

  // a failed series reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == '0)
    else $error("failed result with nonzero value");

  // result stays within [-1, 1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(m_tdata_o) <= 32'sd1073741824) &&
                   ($signed(m_tdata_o) >= -32'sd1073741824))
    else $error("result out of range");

endmodule

bind taylor_sine_cosine tsc_chk u_tsc_chk (.*);

### tb/sv/tb_taylor_sine_cosine.sv
`timescale 1ns / 100ps

module tb_taylor_sine_cosine;
  import tsc_pkg::*;

  localparam logic MODE_COS = 1'b0;
  localparam logic MODE_SIN = 1'b1;

  localparam logic [PADDR_W-1:0] TOL_ADDR = PADDR_W'(4 * int'(REG_TOL));

  localparam longint ANG_PI     = 52707179;
  localparam longint ANG_TWO_PI = 105414358;
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;

  localparam logic [ANGLE_W-1:0] PI_ANG      = ANGLE_W'(ANG_PI);
  localparam logic [ANGLE_W-1:0] HALF_PI_ANG = ANGLE_W'(26353589);
  localparam logic [ANGLE_W-1:0] ONE_ANG     = ANGLE_W'(32'h0100_0000);

  localparam int unsigned CALM_LO = 900;
  localparam int unsigned CALM_HI = 1200;
  localparam int unsigned HOLD_AT = 300;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               failed;
  } trig_res_t;

  typedef struct packed {
    logic [TOL_W-1:0]   tol;
    logic [ANGLE_W-1:0] angle;
    logic               mode;
    logic               fixed;
    logic [VALUE_W-1:0] value;
    logic               failed;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready_o;
  logic [ANGLE_W-1:0] s_tdata;   // angle
  logic               s_tuser;   // mode
  logic               m_tvalid_o;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata_o; // value
  logic               m_tuser_o; // failed
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata_o;
  logic               pready_o;

  trig_res_t        expected_q[$];
  logic [TOL_W-1:0] tol_now = TOL_RESET;
  int unsigned      mismatches = 0;
  int unsigned      sent = 0;
  int unsigned      words_taken = 0;
  int unsigned      hold_cycles = 0;
  logic             hold_used = 1'b0;

  taylor_sine_cosine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // fixed-point taylor series, same rounding as the datapath
  function automatic trig_res_t taylor_predict(input logic [ANGLE_W-1:0] angle,
                                               input logic sine,
                                               input logic [TOL_W-1:0] tol);
    longint      x;
    longint      sum;
    logic        neg;
    logic        minus;
    logic        failed;
    logic [63:0] ax;
    logic [63:0] xx;
    logic [63:0] term;
    logic [63:0] d;
    int          n;
    trig_res_t   res;
    x = longint'($signed(angle));
    while (x > ANG_PI) x -= ANG_TWO_PI;
    while (x <= -ANG_PI) x += ANG_TWO_PI;
    neg = x < 0;
    ax = 64'(neg ? -x : x) << 6;
    xx = (ax * ax + Q30_HALF) >> 30;
    term = sine ? ax : Q30_ONE;
    n = sine ? 1 : 0;
    sum = longint'(term);
    minus = 1'b1;
    failed = 1'b0;
    forever begin
      if (n > ORDER_LIMIT_DEF) begin
        failed = 1'b1;
        break;
      end
      n += 2;
      d = 64'(n * (n - 1));
      term = (term >> 30) * xx + (((term & (Q30_ONE - 1)) * xx + Q30_HALF) >> 30);
      term = (term + d / 2) / d;
      if (minus) sum -= longint'(term);
      else sum += longint'(term);
      minus = !minus;
      if (term < 64'(tol)) break;
    end
    if (failed) begin
      sum = 0;
    end else begin
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      if (sum < -longint'(Q30_ONE)) sum = -longint'(Q30_ONE);
      if (sine && neg) sum = -sum;
    end
    res.value = sum[VALUE_W-1:0];
    res.failed = failed;
    return res;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] off;
    longint             k;
    off = ANGLE_W'($urandom_range(0, 8)) - ANGLE_W'(4);
    k = longint'($urandom_range(0, 19));
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return ANGLE_W'($urandom_range(0, 105414357)) - (PI_ANG - ANGLE_W'(1));
      // odd multiples of pi, where the fold lands on its boundary
      6: return ($urandom_range(1) ? ANGLE_W'(ANG_PI + k * ANG_TWO_PI)
                                   : ANGLE_W'(-ANG_PI - k * ANG_TWO_PI)) + off;
      7: return $urandom_range(1) ? ANGLE_W'($urandom_range(0, 2047))
                                  : -ANGLE_W'($urandom_range(0, 2047));
      8: return ($urandom_range(1) ? HALF_PI_ANG : -HALF_PI_ANG)
                + ANGLE_W'($urandom_range(0, 4095)) - ANGLE_W'(2048);
      default: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                      ^ ANGLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic [ANGLE_W-1:0] angle, input logic mode,
                           input logic fixed, input trig_res_t fixed_res);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_tready_o);
    expected_q.push_back(fixed ? fixed_res : taylor_predict(angle, mode, tol_now));
    sent++;
    if (!(sent >= CALM_LO && sent < CALM_HI) && $urandom_range(99) < 32) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  // write, then read back through the same port
  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOL_ADDR;
    pwdata  <= {16'($urandom), tol};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    tol_now = tol;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (prdata_o !== PDATA_W'(tol)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tolerance readback: expected %h, got %h", PDATA_W'(tol), prdata_o);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: random backpressure, one long hold-off, one calm stretch
  always @(posedge clk_i) begin
    if (s_tvalid && s_tready_o) words_taken <= words_taken + 1;
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (!hold_used && words_taken >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_cycles <= 800;
      m_tready <= 1'b0;
    end else if (words_taken >= CALM_LO && words_taken < CALM_HI) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk_i) begin : check_results
    trig_res_t want;
    if (rst_ni && m_tvalid_o && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %h failed %b", m_tdata_o, m_tuser_o);
      end else begin
        want = expected_q.pop_front();
        if (m_tdata_o !== want.value || m_tuser_o !== want.failed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: value expected %h got %h, failed expected %b got %b",
                     want.value, m_tdata_o, want.failed, m_tuser_o);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t        plan [23];
    logic [TOL_W-1:0] tol;
    int unsigned      count;
    plan = '{
      '{16'd1, 32'h0, MODE_COS, 1'b1, 32'h4000_0000, 1'b0},
      '{16'd1, 32'h0, MODE_SIN, 1'b1, 32'h0, 1'b0},
      '{16'd1, 32'h7FFF_FFFF, MODE_COS, 1'b0, 32'h0, 1'b0},
      '{16'd1, 32'h7FFF_FFFF, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, 32'h8000_0000, MODE_COS, 1'b0, 32'h0, 1'b0},
      '{16'd1, 32'h8000_0000, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, PI_ANG, MODE_COS, 1'b0, 32'h0, 1'b0},
      '{16'd1, PI_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, -PI_ANG, MODE_COS, 1'b0, 32'h0, 1'b0},
      '{16'd1, -PI_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, PI_ANG + 32'd1, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, 32'd1 - PI_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, 32'hFFFF_FFFF, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, ONE_ANG, MODE_COS, 1'b0, 32'h0, 1'b0},
      '{16'd1, -ONE_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'd1, HALF_PI_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      // coarse tolerance: early stop, seed below tolerance is still summed
      '{16'hFFFF, HALF_PI_ANG, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'hFFFF, 32'h0, MODE_COS, 1'b1, 32'h4000_0000, 1'b0},
      '{16'hFFFF, 32'h1, MODE_SIN, 1'b0, 32'h0, 1'b0},
      '{16'hFFFF, 32'h0080_0000, MODE_COS, 1'b0, 32'h0, 1'b0},
      // zero tolerance never converges
      '{16'd0, 32'h0, MODE_COS, 1'b1, 32'h0, 1'b1},
      '{16'd0, 32'h7FFF_FFFF, MODE_SIN, 1'b1, 32'h0, 1'b1},
      '{16'd0, 32'h0, MODE_SIN, 1'b1, 32'h0, 1'b1}
    };
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].tol != tol_now) begin
        wait_drained();
        write_tolerance(plan[i].tol);
      end
      send_word(plan[i].angle, plan[i].mode, plan[i].fixed,
                '{plan[i].value, plan[i].failed});
    end

    for (int p = 0; p < 7; p++) begin
      count = 330;
      case (p)
        0: tol = TOL_W'(1);
        1: tol = TOL_W'(16'hFFFF);
        2: begin
          tol = TOL_W'(0);
          count = 12;
        end
        3: tol = TOL_W'($urandom_range(2, 64));
        4: tol = TOL_W'($urandom_range(1, 65535));
        5: tol = TOL_W'($urandom_range(1, 8));
        default: tol = TOL_W'($urandom_range(1, 65535));
      endcase
      wait_drained();
      write_tolerance(tol);
      repeat (count) begin
        send_word(pick_angle(), 1'($urandom_range(1)), 1'b0, '0);
        if (sent == 600) wait_drained();
      end
    end

    wait_drained();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### taylor_sine_cosine.f
sv/tsc_pkg.sv
sv/tsc_ctrl.sv
sv/tsc_dp.sv
sv/taylor_sine_cosine.sv
sv/tsc_chk.sv
tb/sv/tb_taylor_sine_cosine.sv
